[src/cpsf_pkg.sv]
// Shared item codes and control types for the column pair subcluster former.
`timescale 1ns / 1ps
package cpsf_pkg;

	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_EVENT  = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic push0;
		logic push1;
	} push_t;

endpackage

[src/cpsf_box.sv]
// Box state and per-item decision logic for the subcluster former.
`timescale 1ns / 1ps
module cpsf_box #(
	parameter int COL_BITS = 10,
	parameter int ROW_BITS = 9,
	parameter int ID_BITS = 16,
	parameter int WORD_BITS = 3 + ID_BITS + 2 * COL_BITS + 2 * ROW_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [1:0]           kind,
	input  logic [ID_BITS-1:0]   event_id,
	input  logic [COL_BITS-1:0]  pixel_col,
	input  logic [ROW_BITS-1:0]  pixel_row,
	output cpsf_pkg::push_t      push,
	output logic [WORD_BITS-1:0] word0,
	output logic [WORD_BITS-1:0] word1
);

	localparam logic signed [COL_BITS:0] COL_ONE = (COL_BITS + 1)'(1);
	localparam logic signed [ROW_BITS:0] ROW_ONE = (ROW_BITS + 1)'(1);

	logic                awaiting_q, awaiting_d;
	logic                box_open_q, box_open_d;
	logic [COL_BITS-1:0] prev_col_q, prev_col_d;
	logic [ROW_BITS-1:0] prev_row_q, prev_row_d;
	logic [COL_BITS-1:0] left_q, left_d, right_q, right_d;
	logic [ROW_BITS-1:0] top_q, top_d, bottom_q, bottom_d;

	logic signed [COL_BITS:0] col_step;
	logic signed [ROW_BITS:0] row_step;
	logic                     split;
	logic                     use_box0;
	logic                     box_last;
	logic [1:0]               mark_kind;
	logic [ID_BITS-1:0]       mark_id;
	logic [WORD_BITS-1:0]     box_w, mark_w;

	assign col_step = $signed({1'b0, pixel_col}) - $signed({1'b0, prev_col_q});
	assign row_step = $signed({1'b0, pixel_row}) - $signed({1'b0, prev_row_q});
	assign split = (col_step > COL_ONE) || (row_step > ROW_ONE)
		|| (pixel_col[COL_BITS-1:1] != prev_col_q[COL_BITS-1:1]);

	assign mark_kind = awaiting_q ? cpsf_pkg::KIND_EVENT : kind;
	assign mark_id = (!awaiting_q && kind == cpsf_pkg::KIND_END) ? '0 : event_id;

	assign box_w = {box_last, bottom_q, top_q, right_q, left_q, {ID_BITS{1'b0}},
		cpsf_pkg::KIND_PIXEL};
	assign mark_w = {1'b1, {(2 * ROW_BITS){1'b0}}, {(2 * COL_BITS){1'b0}}, mark_id,
		mark_kind};

	assign word0 = use_box0 ? box_w : mark_w;
	assign word1 = mark_w;

	always_comb begin
		push = '0;
		use_box0 = 1'b0;
		box_last = 1'b0;
		awaiting_d = awaiting_q;
		box_open_d = box_open_q;
		prev_col_d = prev_col_q;
		prev_row_d = prev_row_q;
		left_d = left_q;
		right_d = right_q;
		top_d = top_q;
		bottom_d = bottom_q;
		if (fire && kind != cpsf_pkg::KIND_UNUSED) begin
			if (awaiting_q) begin
				awaiting_d = 1'b0;
				box_open_d = 1'b0;
				push.push0 = 1'b1;
			end else if (kind == cpsf_pkg::KIND_PIXEL) begin
				prev_col_d = pixel_col;
				prev_row_d = pixel_row;
				if (!box_open_q || split) begin
					left_d = pixel_col;
					right_d = pixel_col;
					top_d = pixel_row;
					bottom_d = pixel_row;
					box_open_d = 1'b1;
					if (box_open_q) begin
						push.push0 = 1'b1;
						use_box0 = 1'b1;
						box_last = 1'b1;
					end
				end else begin
					if (pixel_col < left_q) begin
						left_d = pixel_col;
					end
					if (pixel_col > right_q) begin
						right_d = pixel_col;
					end
					if (pixel_row > bottom_q) begin
						bottom_d = pixel_row;
					end
				end
			end else begin
				box_open_d = 1'b0;
				push.push0 = 1'b1;
				if (box_open_q) begin
					use_box0 = 1'b1;
					push.push1 = 1'b1;
				end
				if (kind == cpsf_pkg::KIND_END) begin
					awaiting_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			box_open_q <= 1'b0;
			prev_col_q <= '0;
			prev_row_q <= '0;
			left_q <= '0;
			right_q <= '0;
			top_q <= '0;
			bottom_q <= '0;
		end else begin
			awaiting_q <= awaiting_d;
			box_open_q <= box_open_d;
			prev_col_q <= prev_col_d;
			prev_row_q <= prev_row_d;
			left_q <= left_d;
			right_q <= right_d;
			top_q <= top_d;
			bottom_q <= bottom_d;
		end
	end

endmodule

[src/cpsf_fifo.sv]
// Four-word result queue that takes up to two words per cycle.
`timescale 1ns / 1ps
module cpsf_fifo #(
	parameter int WORD_BITS = 59
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cpsf_pkg::push_t      push,
	input  logic [WORD_BITS-1:0] word0,
	input  logic [WORD_BITS-1:0] word1,
	input  logic                 stall,
	output logic                 valid,
	output logic [WORD_BITS-1:0] head,
	output logic                 full
);

	localparam int DEPTH = 4;
	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [CNT_BITS-1:0] ROOM_LIMIT = CNT_BITS'(DEPTH - 2);

	logic [WORD_BITS-1:0] mem_q [DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q, wr_next;
	logic [CNT_BITS-1:0]  cnt_q, n_push;
	logic                 pop;

	assign valid = (cnt_q != '0);
	assign full = (cnt_q > ROOM_LIMIT);
	assign head = mem_q[rd_ptr_q];
	assign pop = valid && !stall;
	assign wr_next = wr_ptr_q + PTR_BITS'(1);
	assign n_push = CNT_BITS'(push.push0) + CNT_BITS'(push.push1);

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= word0;
		end
		if (push.push1) begin
			mem_q[wr_next] <= word1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			cnt_q <= cnt_q + n_push - CNT_BITS'(pop);
		end
	end

endmodule

[src/column_pair_subcluster_former_top.sv]
// A result word is registered in the result queue and offered once the words ahead of it have left.
// Throughput: one hit word per cycle while hit_stall is low; markers that flush a box add a second result.
// A four-word result queue decouples the sides; hit_stall rises with under two slots free.
// Reset: asynchronous, clears the queue and the open box; the next word of a used kind opens an event.
`timescale 1ns / 1ps
module column_pair_subcluster_former_top #(
	parameter int COL_BITS = 10,
	parameter int ROW_BITS = 9,
	parameter int ID_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hit_valid,
	output logic                hit_stall,
	input  logic [1:0]          kind,
	input  logic [ID_BITS-1:0]  event_id,
	input  logic [COL_BITS-1:0] pixel_col,
	input  logic [ROW_BITS-1:0] pixel_row,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [1:0]          out_kind,
	output logic [ID_BITS-1:0]  out_event_id,
	output logic [COL_BITS-1:0] box_left,
	output logic [COL_BITS-1:0] box_right,
	output logic [ROW_BITS-1:0] box_top,
	output logic [ROW_BITS-1:0] box_bottom,
	output logic                last
);

	localparam int WORD_BITS = 3 + ID_BITS + 2 * COL_BITS + 2 * ROW_BITS;

	cpsf_pkg::push_t      push;
	logic [WORD_BITS-1:0] word0, word1, head;
	logic                 fire;

	assign fire = hit_valid && !hit_stall;

	cpsf_box #(
		.COL_BITS(COL_BITS),
		.ROW_BITS(ROW_BITS),
		.ID_BITS(ID_BITS),
		.WORD_BITS(WORD_BITS)
	) u_box (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.kind(kind),
		.event_id(event_id),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.push(push),
		.word0(word0),
		.word1(word1)
	);

	cpsf_fifo #(
		.WORD_BITS(WORD_BITS)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.word0(word0),
		.word1(word1),
		.stall(res_stall),
		.valid(res_valid),
		.head(head),
		.full(hit_stall)
	);

	assign {last, box_bottom, box_top, box_right, box_left, out_event_id, out_kind} = head;

endmodule

[src/cpsf_checker.sv]
// Port-level checks for the subcluster former, bound to the top level.
`timescale 1ns / 1ps
module cpsf_checker #(
	parameter int COL_BITS = 10,
	parameter int ROW_BITS = 9,
	parameter int ID_BITS = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                hit_valid,
	input logic                hit_stall,
	input logic [1:0]          kind,
	input logic                res_valid,
	input logic                res_stall,
	input logic [1:0]          out_kind,
	input logic [ID_BITS-1:0]  out_event_id,
	input logic                last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result word dropped while stalled");

	a_stall_backed: assert property (@(posedge clk) disable iff (!arst_n)
		hit_stall |-> res_valid)
		else $error("hit side stalled with no result pending");

	a_box_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_kind == cpsf_pkg::KIND_PIXEL |-> out_event_id == '0)
		else $error("box word carries an event id");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_kind != cpsf_pkg::KIND_PIXEL |-> last)
		else $error("marker word not flagged last");

	a_event_yields: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && hit_valid && !hit_stall && kind == cpsf_pkg::KIND_EVENT |=> res_valid)
		else $error("event word produced no result");

endmodule

bind column_pair_subcluster_former_top cpsf_checker #(
	.COL_BITS(COL_BITS),
	.ROW_BITS(ROW_BITS),
	.ID_BITS(ID_BITS)
) u_cpsf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.hit_valid(hit_valid),
	.hit_stall(hit_stall),
	.kind(kind),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.out_kind(out_kind),
	.out_event_id(out_event_id),
	.last(last)
);

[tb/sv/subcluster_checker.sv]
// Checker for the subcluster former: predicts result words from accepted hit words.
`timescale 1ns / 1ps
module subcluster_checker #(
	parameter int COL_BITS = 10,
	parameter int ROW_BITS = 9,
	parameter int ID_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hit_valid,
	input  logic                hit_stall,
	input  logic [1:0]          kind,
	input  logic [ID_BITS-1:0]  event_id,
	input  logic [COL_BITS-1:0] pixel_col,
	input  logic [ROW_BITS-1:0] pixel_row,
	input  logic                res_valid,
	input  logic                res_stall,
	input  logic [1:0]          out_kind,
	input  logic [ID_BITS-1:0]  out_event_id,
	input  logic [COL_BITS-1:0] box_left,
	input  logic [COL_BITS-1:0] box_right,
	input  logic [ROW_BITS-1:0] box_top,
	input  logic [ROW_BITS-1:0] box_bottom,
	input  logic                last,
	output int                  fail_count,
	output int                  words_owed
);

	typedef struct packed {
		logic [1:0]          kind;
		logic [ID_BITS-1:0]  id;
		logic [COL_BITS-1:0] left;
		logic [COL_BITS-1:0] right;
		logic [ROW_BITS-1:0] top;
		logic [ROW_BITS-1:0] bottom;
		logic                last;
	} sub_word_t;

	sub_word_t owed_words[$];

	logic                stream_fresh;
	logic                box_open;
	logic [COL_BITS-1:0] prev_col;
	logic [ROW_BITS-1:0] prev_row;
	logic [COL_BITS-1:0] left_edge;
	logic [COL_BITS-1:0] right_edge;
	logic [ROW_BITS-1:0] top_edge;
	logic [ROW_BITS-1:0] bottom_edge;

	function automatic sub_word_t marker_word(logic [1:0] k, logic [ID_BITS-1:0] id);
		sub_word_t w;
		w = '0;
		w.kind = k;
		w.id = id;
		w.last = 1'b1;
		return w;
	endfunction

	task automatic open_box(logic [COL_BITS-1:0] c, logic [ROW_BITS-1:0] r);
		left_edge = c;
		right_edge = c;
		top_edge = r;
		bottom_edge = r;
		box_open = 1'b1;
	endtask

	task automatic flush_box(logic is_last);
		sub_word_t w;
		w = '0;
		w.kind = cpsf_pkg::KIND_PIXEL;
		w.left = left_edge;
		w.right = right_edge;
		w.top = top_edge;
		w.bottom = bottom_edge;
		w.last = is_last;
		owed_words.push_back(w);
	endtask

	task automatic fold_word(logic [1:0] k, logic [ID_BITS-1:0] id,
			logic [COL_BITS-1:0] c, logic [ROW_BITS-1:0] r);
		int dc;
		int dr;
		int step;
		if (k == cpsf_pkg::KIND_UNUSED)
			return;
		if (stream_fresh) begin
			stream_fresh = 1'b0;
			box_open = 1'b0;
			owed_words.push_back(marker_word(cpsf_pkg::KIND_EVENT, id));
			return;
		end
		if (k == cpsf_pkg::KIND_PIXEL) begin
			if (!box_open) begin
				open_box(c, r);
			end else begin
				dc = int'(c) - int'(prev_col);
				dr = int'(r) - int'(prev_row);
				step = (dc > dr) ? dc : dr;
				if (step > 1 || (c >> 1) != (prev_col >> 1)) begin
					flush_box(1'b1);
					open_box(c, r);
				end else begin
					if (c < left_edge)
						left_edge = c;
					if (c > right_edge)
						right_edge = c;
					if (r > bottom_edge)
						bottom_edge = r;
				end
			end
			prev_col = c;
			prev_row = r;
		end else begin
			if (box_open)
				flush_box(1'b0);
			box_open = 1'b0;
			if (k == cpsf_pkg::KIND_EVENT) begin
				owed_words.push_back(marker_word(cpsf_pkg::KIND_EVENT, id));
			end else begin
				owed_words.push_back(marker_word(cpsf_pkg::KIND_END, '0));
				stream_fresh = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sub_word_t seen;
		sub_word_t due;
		if (!arst_n) begin
			stream_fresh = 1'b1;
			box_open = 1'b0;
			prev_col = '0;
			prev_row = '0;
			left_edge = '0;
			right_edge = '0;
			top_edge = '0;
			bottom_edge = '0;
			owed_words.delete();
			fail_count = 0;
		end else begin
			if (hit_valid && !hit_stall)
				fold_word(kind, event_id, pixel_col, pixel_row);
			if (res_valid && !res_stall) begin
				seen = '{out_kind, out_event_id, box_left, box_right, box_top,
					box_bottom, last};
				if (owed_words.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected word kind=%0d id=%0h box=%0d..%0d x %0d..%0d last=%0b",
						$time, seen.kind, seen.id, seen.left, seen.right, seen.top,
						seen.bottom, seen.last);
				end else begin
					due = owed_words.pop_front();
					if (seen !== due) begin
						fail_count++;
						$display("%0t: mismatch expected kind=%0d id=%0h l=%0d r=%0d t=%0d b=%0d last=%0b",
							$time, due.kind, due.id, due.left, due.right, due.top,
							due.bottom, due.last);
						$display("%0t:          actual kind=%0d id=%0h l=%0d r=%0d t=%0d b=%0d last=%0b",
							$time, seen.kind, seen.id, seen.left, seen.right, seen.top,
							seen.bottom, seen.last);
					end
				end
			end
		end
		words_owed = owed_words.size();
	end

endmodule

[tb/sv/tb.sv]
// Testbench top for the subcluster former: clock, reset, hit stimulus, result stalls, verdict.
`timescale 1ns / 1ps
module tb;

	localparam int COL_BITS = 10;
	localparam int ROW_BITS = 9;
	localparam int ID_BITS = 16;
	localparam int RANDOM_WORDS = 800;
	localparam int CYCLE_LIMIT = 600000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                hit_valid = 1'b0;
	logic                hit_stall;
	logic [1:0]          kind = cpsf_pkg::KIND_PIXEL;
	logic [ID_BITS-1:0]  event_id = '0;
	logic [COL_BITS-1:0] pixel_col = '0;
	logic [ROW_BITS-1:0] pixel_row = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic [1:0]          out_kind;
	logic [ID_BITS-1:0]  out_event_id;
	logic [COL_BITS-1:0] box_left;
	logic [COL_BITS-1:0] box_right;
	logic [ROW_BITS-1:0] box_top;
	logic [ROW_BITS-1:0] box_bottom;
	logic                last;

	int fail_count;
	int words_owed;
	int words_sent = 0;
	int cycles = 0;
	logic [COL_BITS-1:0] walk_col = '0;
	logic [ROW_BITS-1:0] walk_row = '0;

	column_pair_subcluster_former_top #(
		.COL_BITS(COL_BITS),
		.ROW_BITS(ROW_BITS),
		.ID_BITS(ID_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.hit_valid(hit_valid),
		.hit_stall(hit_stall),
		.kind(kind),
		.event_id(event_id),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_kind(out_kind),
		.out_event_id(out_event_id),
		.box_left(box_left),
		.box_right(box_right),
		.box_top(box_top),
		.box_bottom(box_bottom),
		.last(last)
	);

	subcluster_checker #(
		.COL_BITS(COL_BITS),
		.ROW_BITS(ROW_BITS),
		.ID_BITS(ID_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.hit_valid(hit_valid),
		.hit_stall(hit_stall),
		.kind(kind),
		.event_id(event_id),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_kind(out_kind),
		.out_event_id(out_event_id),
		.box_left(box_left),
		.box_right(box_right),
		.box_top(box_top),
		.box_bottom(box_bottom),
		.last(last),
		.fail_count(fail_count),
		.words_owed(words_owed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if ((words_sent / 64) % 3 == 0)
			return 0;
		r = $urandom_range(99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic push_word(logic [1:0] k, logic [ID_BITS-1:0] id,
			logic [COL_BITS-1:0] c, logic [ROW_BITS-1:0] r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			hit_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hit_valid <= 1'b1;
		kind <= k;
		event_id <= id;
		pixel_col <= c;
		pixel_row <= r;
		@(posedge clk);
		while (hit_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic push_random_hit();
		int dc;
		int dr;
		if ($urandom_range(99) < 85) begin
			dc = $urandom_range(3) - 1;
			dr = $urandom_range(3) - 1;
			walk_col = walk_col + COL_BITS'(dc);
			walk_row = walk_row + ROW_BITS'(dr);
		end else begin
			walk_col = COL_BITS'($urandom_range(1023));
			walk_row = ROW_BITS'($urandom_range(511));
		end
		push_word(cpsf_pkg::KIND_PIXEL, ID_BITS'($urandom_range(65535)), walk_col, walk_row);
	endtask

	// hold off the result side once for a long stretch, otherwise stall at random
	initial begin
		int r;
		int span;
		bit long_hold_done;
		long_hold_done = 0;
		forever begin
			if (!long_hold_done && words_sent >= 350) begin
				res_stall <= 1'b1;
				repeat (400) @(posedge clk);
				long_hold_done = 1;
			end else begin
				r = $urandom_range(99);
				if (r < 60) begin
					res_stall <= 1'b0;
					span = $urandom_range(20, 1);
				end else if (r < 95) begin
					res_stall <= 1'b1;
					span = $urandom_range(3, 1);
				end else begin
					res_stall <= 1'b1;
					span = $urandom_range(60, 20);
				end
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin
		int real_words;
		int r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_word(cpsf_pkg::KIND_PIXEL, 16'hFFFF, 10'd1023, 9'd511);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h0000, 10'd0, 9'd0);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h0000, 10'd1, 9'd1);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h0000, 10'd0, 9'd2);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h0000, 10'd2, 9'd2);
		push_word(cpsf_pkg::KIND_UNUSED, 16'hFFFF, 10'd1023, 9'd511);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h0000, 10'd3, 9'd0);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h0000, 10'd3, 9'd3);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h0000, 10'd1023, 9'd511);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h0000, 10'd1022, 9'd510);
		push_word(cpsf_pkg::KIND_EVENT, 16'h0000, 10'd0, 9'd0);
		push_word(cpsf_pkg::KIND_EVENT, 16'h1234, 10'd1023, 9'd511);
		push_word(cpsf_pkg::KIND_PIXEL, 16'hFFFF, 10'd5, 9'd7);
		push_word(cpsf_pkg::KIND_END, 16'hFFFF, 10'd1023, 9'd511);
		push_word(cpsf_pkg::KIND_UNUSED, 16'h0000, 10'd0, 9'd0);
		push_word(cpsf_pkg::KIND_END, 16'hAAAA, 10'd0, 9'd0);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h0000, 10'd0, 9'd0);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h0000, 10'd0, 9'd0);
		push_word(cpsf_pkg::KIND_END, 16'h0000, 10'd0, 9'd0);
		push_word(cpsf_pkg::KIND_EVENT, 16'h5555, 10'd0, 9'd0);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h0000, 10'd1022, 9'd0);
		push_word(cpsf_pkg::KIND_END, 16'h0000, 10'd0, 9'd0);
		push_word(cpsf_pkg::KIND_PIXEL, 16'h00FF, 10'd512, 9'd256);
		push_word(cpsf_pkg::KIND_END, 16'h0000, 10'd0, 9'd0);
		push_word(cpsf_pkg::KIND_EVENT, 16'hFF00, 10'd0, 9'd0);

		real_words = 0;
		while (real_words < RANDOM_WORDS) begin
			r = $urandom_range(99);
			if (r < 3) begin
				push_word(cpsf_pkg::KIND_UNUSED, ID_BITS'($urandom_range(65535)),
					COL_BITS'($urandom_range(1023)), ROW_BITS'($urandom_range(511)));
				real_words--;
			end else if (r < 6) begin
				push_word(cpsf_pkg::KIND_END, ID_BITS'($urandom_range(65535)),
					COL_BITS'($urandom_range(1023)), ROW_BITS'($urandom_range(511)));
			end else if (r < 11) begin
				push_word(cpsf_pkg::KIND_EVENT, ID_BITS'($urandom_range(65535)),
					COL_BITS'($urandom_range(1023)), ROW_BITS'($urandom_range(511)));
			end else begin
				push_random_hit();
			end
			real_words++;
		end
		hit_valid <= 1'b0;

		@(posedge clk);
		while (words_owed != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
